// ===== hdl/sliding_window_median_defines.svh =====
// Assertion macros for the sliding window median checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swm_pkg.sv =====
// Shared constants and types for the sliding window median filter.
// No dependencies.
package swm_pkg;

  localparam int WINDOW_DEF      = 9;
  localparam int SAMPLE_BITS_DEF = 16;

  // control handed from the top level to one cell
  typedef struct packed {
    logic rm_here;   // removed entry sits at this cell or below it
    logic rm_left;   // removed entry sits at the left neighbor or below it
  } cell_ctl_t;

  // status one cell shows to its neighbors and the top level
  typedef struct packed {
    logic le;        // stored value is less than or equal to the new sample
    logic oldest;    // stored entry has the greatest age
  } cell_stat_t;

endpackage

// ===== hdl/swm_cell.sv =====
// One cell of the sorted window chain: holds one value and its age.
// Depends on swm_pkg for the control and status structs.
module swm_cell #(
  parameter int WINDOW      = swm_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  parameter int AGE_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  parameter int IDX         = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] left_value,
  input  logic        [AGE_BITS-1:0]    left_age,
  input  swm_pkg::cell_stat_t           left_stat,
  input  logic signed [SAMPLE_BITS-1:0] right_value,
  input  logic        [AGE_BITS-1:0]    right_age,
  input  swm_pkg::cell_stat_t           right_stat,
  input  swm_pkg::cell_ctl_t            ctl,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic        [AGE_BITS-1:0]    age,
  output logic signed [SAMPLE_BITS-1:0] value_next,
  output swm_pkg::cell_stat_t           stat
);
  import swm_pkg::*;

  localparam bit FIRST = (IDX == 0);
  localparam bit LAST  = (IDX == WINDOW - 1);

  logic                          here_le;
  logic                          left_le;
  logic signed [SAMPLE_BITS-1:0] here_src;
  logic        [AGE_BITS-1:0]    here_src_age;
  logic signed [SAMPLE_BITS-1:0] left_src;
  logic        [AGE_BITS-1:0]    left_src_age;
  logic        [AGE_BITS-1:0]    age_next;

  always_comb begin
    stat.le     = (value <= sample);
    stat.oldest = (age == AGE_BITS'(WINDOW - 1));
  end

  // entry at this place and at the place to the left once the oldest is dropped
  always_comb begin
    here_src     = ctl.rm_here ? right_value : value;
    here_src_age = ctl.rm_here ? right_age : age;
    here_le      = LAST ? 1'b0 : (ctl.rm_here ? right_stat.le : stat.le);
    left_src     = ctl.rm_left ? value : left_value;
    left_src_age = ctl.rm_left ? age : left_age;
    left_le      = FIRST ? 1'b1 : (ctl.rm_left ? stat.le : left_stat.le);
  end

  // keep or take the right neighbor, take the new sample, or shift up by one
  always_comb begin
    if (here_le) begin
      value_next = here_src;
      age_next   = here_src_age + AGE_BITS'(1);
    end else if (left_le) begin
      value_next = sample;
      age_next   = '0;
    end else begin
      value_next = left_src;
      age_next   = left_src_age + AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= AGE_BITS'(IDX);
    end else if (advance) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// ===== hdl/sliding_window_median.sv =====
// Sliding window median filter: a sorted chain of WINDOW cells plus an output register.
// median_valid is registered and rises in the cycle after the sample is accepted.
// Throughput: one item per cycle while not stalled; the cell chain drops, shifts and inserts in one step.
// A new item is taken while the output register is empty or being read.
// Synchronous reset loads WINDOW zeros with ages 0 to WINDOW-1 and empties the output.
// Depends on swm_pkg and swm_cell.
module sliding_window_median #(
  parameter int WINDOW      = swm_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          median_valid,
  input  logic                          median_stall,
  output logic signed [SAMPLE_BITS-1:0] median_value
);
  import swm_pkg::*;

  localparam int AGE_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID      = WINDOW / 2;

  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW];
  logic        [AGE_BITS-1:0]    cell_age   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_next  [WINDOW];
  cell_stat_t                    cell_stat  [WINDOW];
  cell_ctl_t                     cell_ctl   [WINDOW];
  logic        [WINDOW-1:0]      oldest_vec;
  logic        [WINDOW-1:0]      rm_at_or_below;
  logic signed [SAMPLE_BITS-1:0] median_next;

  assign sample_stall = median_valid && median_stall;
  assign accept       = sample_valid && !sample_stall;

  // cells at or above the oldest entry take their right neighbor
  assign rm_at_or_below = ~(oldest_vec - WINDOW'(1));

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == WINDOW - 1) ? i : i + 1;

    assign oldest_vec[i]       = cell_stat[i].oldest;
    assign cell_ctl[i].rm_here = rm_at_or_below[i];
    assign cell_ctl[i].rm_left = (i == 0) ? 1'b0 : rm_at_or_below[L];

    swm_cell #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS),
      .IDX         (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (accept),
      .sample      (sample),
      .left_value  (cell_value[L]),
      .left_age    (cell_age[L]),
      .left_stat   (cell_stat[L]),
      .right_value (cell_value[R]),
      .right_age   (cell_age[R]),
      .right_stat  (cell_stat[R]),
      .ctl         (cell_ctl[i]),
      .value       (cell_value[i]),
      .age         (cell_age[i]),
      .value_next  (cell_next[i]),
      .stat        (cell_stat[i])
    );
  end

  if ((WINDOW % 2) == 1) begin : g_odd
    assign median_next = cell_next[MID];
  end else begin : g_even
    logic signed [SAMPLE_BITS:0] pair_sum;
    logic signed [SAMPLE_BITS:0] pair_adj;
    // round toward zero: add one to a negative sum before the shift
    always_comb begin
      pair_sum = {cell_next[MID-1][SAMPLE_BITS-1], cell_next[MID-1]}
               + {cell_next[MID][SAMPLE_BITS-1], cell_next[MID]};
      pair_adj = pair_sum + {{SAMPLE_BITS{1'b0}}, pair_sum[SAMPLE_BITS]};
    end
    assign median_next = pair_adj[SAMPLE_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (accept) begin
      median_valid <= 1'b1;
    end else if (!median_stall) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median_value <= median_next;
    end
  end

endmodule

// ===== hdl/swm_checker.sv =====
// Port-level checks for the sliding window median filter, bound to the top level.
// Depends on sliding_window_median_defines.svh and sliding_window_median.
`include "sliding_window_median_defines.svh"

module swm_checker #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic                          median_valid,
  input logic                          median_stall,
  input logic signed [SAMPLE_BITS-1:0] median_value
);

  logic in_take;

  assign in_take = sample_valid && !sample_stall;

  `SWM_ASSERT_NEXT(a_item_gives_result, in_take, median_valid, "accepted item gave no result")
  `SWM_ASSERT_NEXT(a_no_invented_result, !median_valid && !in_take, !median_valid,
                   "result without item")
  `SWM_ASSERT_NOW(a_stall_only_when_full, sample_stall, median_valid && median_stall,
                  "needless stall")
  `SWM_ASSERT_NEXT(a_held_result_stable, median_valid && median_stall,
                   median_valid && $stable(median_value), "held result changed")
  `SWM_ASSERT_NEXT(a_held_sample_stable, sample_valid && sample_stall,
                   sample_valid && $stable(sample), "stalled item changed")

endmodule

bind sliding_window_median swm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (.*);
